/* hw/rtl/sbb_pkg.sv */
// Package for the separable 3x3 box blur: widths, constants, item types and
// the rounded divide-by-three helpers. No dependencies.
`default_nettype none
package sbb_pkg;

	localparam int MAX_COLUMNS = 1024;
	localparam int COL_W       = $clog2(MAX_COLUMNS);
	localparam int LEN_W       = 11;
	localparam int SAMPLE_W    = 32;
	localparam int LINE_W      = 2 * SAMPLE_W;
	localparam int SUM_W       = SAMPLE_W + 2;
	localparam int MAG_W       = SAMPLE_W + 1;
	localparam int RECIP_SHIFT = 34;
	localparam int PROD_W      = 2 * MAG_W;
	localparam int Q_DEPTH     = 4;
	localparam int Q_PTR_W     = $clog2(Q_DEPTH);
	localparam int Q_CNT_W     = $clog2(Q_DEPTH + 2);

	localparam logic [LEN_W-1:0] ROW_LEN_RESET = 11'd4;
	localparam logic [LEN_W-1:0] ROW_LEN_MIN   = 11'd3;
	localparam logic [LEN_W-1:0] ROW_LEN_MAX   = LEN_W'(MAX_COLUMNS);
	localparam logic [COL_W-1:0] COL_FIRST_OUT = COL_W'(2);
	localparam logic [1:0]       ROW_FULL      = 2'd2;

	// ceil(2^34 / 3): exact floor(m / 3) for any m below 2^33
	localparam logic [MAG_W-1:0] RECIP3 = 33'h1_5555_5556;

	typedef struct packed {
		logic row_ok;
		logic col_ok;
		logic last;
	} sbb_flags_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] x;
		logic [SAMPLE_W-1:0] older;
		logic [SAMPLE_W-1:0] prev;
		sbb_flags_t          flags;
	} sbb_item_t;

	function automatic logic [SUM_W-1:0] sbb_sext(input logic [SAMPLE_W-1:0] v);
		return {{(SUM_W-SAMPLE_W){v[SAMPLE_W-1]}}, v};
	endfunction

	// |s| + 1, the rounding offset for round-to-nearest of s / 3
	function automatic logic [MAG_W-1:0] sbb_mag(input logic [SUM_W-1:0] s);
		logic [SUM_W-1:0] t;
		if (s[SUM_W-1])
			t = ~s + SUM_W'(2);
		else
			t = s + SUM_W'(1);
		return t[MAG_W-1:0];
	endfunction

	function automatic logic [SAMPLE_W-1:0] sbb_fin(input logic [PROD_W-1:0] p,
		input logic neg);
		logic [SAMPLE_W-1:0] q;
		q = p[RECIP_SHIFT +: SAMPLE_W];
		return neg ? (~q + SAMPLE_W'(1)) : q;
	endfunction

endpackage
`default_nettype wire

/* hw/rtl/sbb_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module sbb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

/* hw/rtl/sbb_front.sv */
// Front end: row length register, position tracking, line store and item
// classification. Uses sbb_pkg and sbb_ram.
`default_nettype none
module sbb_front import sbb_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [LEN_W-1:0]   cfg_wdata,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [SAMPLE_W-1:0] sample,
	input  wire logic               frame_start,
	input  wire logic [Q_CNT_W-1:0] q_count,
	output logic                    push_valid,
	output sbb_item_t               push_item
);

	logic [LEN_W-1:0]  row_length_q;
	logic [LEN_W-1:0]  len_eff;
	logic [COL_W-1:0]  col_q;
	logic [1:0]        row_q;
	logic [COL_W-1:0]  col_cur;
	logic [1:0]        row_cur;
	logic              last;
	logic              accept;

	logic              valid_s1;
	logic [COL_W-1:0]  col_s1;
	logic [SAMPLE_W-1:0] x_s1;
	sbb_flags_t        flags_s1;
	logic              byp_s1;
	logic [LINE_W-1:0] byp_q;
	logic [LINE_W-1:0] ram_rdata;
	logic [LINE_W-1:0] line;
	logic [LINE_W-1:0] wdata;

	always_comb begin
		if (row_length_q < ROW_LEN_MIN)
			len_eff = ROW_LEN_MIN;
		else if (row_length_q > ROW_LEN_MAX)
			len_eff = ROW_LEN_MAX;
		else
			len_eff = row_length_q;
	end

	assign col_cur  = frame_start ? '0 : col_q;
	assign row_cur  = frame_start ? '0 : row_q;
	assign last     = ({1'b0, col_cur} + LEN_W'(1)) >= len_eff;
	assign in_ready = (q_count + Q_CNT_W'(valid_s1)) < Q_CNT_W'(Q_DEPTH);
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_length_q <= ROW_LEN_RESET;
			col_q        <= '0;
			row_q        <= '0;
			valid_s1     <= 1'b0;
		end else begin
			if (cfg_we)
				row_length_q <= cfg_wdata;
			valid_s1 <= accept;
			if (accept) begin
				if (last) begin
					col_q <= '0;
					row_q <= (row_cur == ROW_FULL) ? ROW_FULL : row_cur + 2'd1;
				end else begin
					col_q <= col_cur + COL_W'(1);
					row_q <= row_cur;
				end
			end
		end
	end

	// line word: {row above, row two above}
	sbb_ram #(.WIDTH(LINE_W), .DEPTH(MAX_COLUMNS)) u_line (
		.clk   (clk),
		.we    (valid_s1),
		.waddr (col_s1),
		.wdata (wdata),
		.raddr (col_cur),
		.rdata (ram_rdata)
	);

	assign line  = byp_s1 ? byp_q : ram_rdata;
	assign wdata = {x_s1, line[LINE_W-1:SAMPLE_W]};

	always_ff @(posedge clk) begin
		byp_q <= wdata;
		if (accept) begin
			col_s1          <= col_cur;
			x_s1            <= sample;
			flags_s1.row_ok <= (row_cur == ROW_FULL);
			flags_s1.col_ok <= (col_cur >= COL_FIRST_OUT);
			flags_s1.last   <= last;
			// same column written this cycle: the RAM still returns old data
			byp_s1          <= valid_s1 && (col_s1 == col_cur);
		end
	end

	assign push_valid      = valid_s1;
	assign push_item.x     = x_s1;
	assign push_item.older = line[SAMPLE_W-1:0];
	assign push_item.prev  = line[LINE_W-1:SAMPLE_W];
	assign push_item.flags = flags_s1;

endmodule
`default_nettype wire

/* hw/rtl/sbb_queue.sv */
// Short item queue between front and back end. Uses sbb_pkg.
`default_nettype none
module sbb_queue import sbb_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push_valid,
	input  sbb_item_t         push_item,
	input  wire logic         pop,
	output logic              head_valid,
	output sbb_item_t         head_item,
	output logic [Q_CNT_W-1:0] count
);

	sbb_item_t            mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_q;
	logic [Q_PTR_W-1:0]   rd_q;
	logic [Q_CNT_W-1:0]   cnt_q;
	logic                 do_pop;

	assign head_valid = (cnt_q != '0);
	assign head_item  = mem_q[rd_q];
	assign count      = cnt_q;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push_valid)
				wr_q <= wr_q + Q_PTR_W'(1);
			if (do_pop)
				rd_q <= rd_q + Q_PTR_W'(1);
			cnt_q <= cnt_q + Q_CNT_W'(push_valid) - Q_CNT_W'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_valid)
			mem_q[wr_q] <= push_item;
	end

endmodule
`default_nettype wire

/* hw/rtl/sbb_back.sv */
// Back end: vertical and horizontal rounded averages, output register.
// Uses sbb_pkg.
`default_nettype none
module sbb_back import sbb_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                head_valid,
	input  sbb_item_t                head_item,
	output logic                     pop,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [SAMPLE_W-1:0]      blurred,
	output logic                     row_end
);

	logic                adv;
	logic [7:1]          v;
	sbb_flags_t          f_s1, f_s2, f_s3, f_s4, f_s5, f_s6, f_s7;
	logic [SUM_W-1:0]    sum_s1, hsum_s5;
	logic [MAG_W-1:0]    mag_s2, mag_s6;
	logic                neg_s2, neg_s3, neg_s6, neg_s7;
	logic [PROD_W-1:0]   prod_s3, prod_s7;
	logic [SAMPLE_W-1:0] vavg_s4;
	logic [SAMPLE_W-1:0] w0_q, w1_q;
	logic                out_valid_q;

	assign adv       = !out_valid_q || out_ready;
	assign pop       = adv;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v           <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v           <= {v[6:1], head_valid};
			out_valid_q <= v[7] && f_s7.row_ok && f_s7.col_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// vertical sum; rows above the first full window count as zero
			f_s1   <= head_item.flags;
			sum_s1 <= head_item.flags.row_ok ?
				sbb_sext(head_item.x) + sbb_sext(head_item.older) + sbb_sext(head_item.prev)
				: '0;
			f_s2   <= f_s1;
			mag_s2 <= sbb_mag(sum_s1);
			neg_s2 <= sum_s1[SUM_W-1];
			f_s3    <= f_s2;
			prod_s3 <= PROD_W'(mag_s2) * PROD_W'(RECIP3);
			neg_s3  <= neg_s2;
			f_s4    <= f_s3;
			vavg_s4 <= sbb_fin(prod_s3, neg_s3);
			// horizontal sum over the vertical-average window
			f_s5    <= f_s4;
			hsum_s5 <= sbb_sext(w0_q) + sbb_sext(w1_q) + sbb_sext(vavg_s4);
			if (v[4]) begin
				w0_q <= w1_q;
				w1_q <= vavg_s4;
			end
			f_s6    <= f_s5;
			mag_s6  <= sbb_mag(hsum_s5);
			neg_s6  <= hsum_s5[SUM_W-1];
			f_s7    <= f_s6;
			prod_s7 <= PROD_W'(mag_s6) * PROD_W'(RECIP3);
			neg_s7  <= neg_s6;
			blurred <= sbb_fin(prod_s7, neg_s7);
			row_end <= f_s7.last;
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/separable_box_blur_3x3.sv */
// Top level of the separable 3x3 box blur (signed Q16.16, rounded /3 twice).
// Uses sbb_pkg, sbb_front, sbb_queue, sbb_back.
//
//   channel  | direction | tdata            | tuser / tlast
//   s_axis   | in        | [31:0] sample    | tuser[0] frame_start
//   m_axis   | out       | [31:0] blurred   | tlast row_end
//   cfg      | in        | [10:0] row_length (cfg_we strobe)
//
// One item per cycle sustained while m_axis is not stalled; an item passes the
// front input register and line store, the 4-entry queue and 8 back stages
// with two 33x33 reciprocal multiplies. The line store is one 1024x64 RAM,
// read and written once per item. Reset clears position, row length (4) and
// all valid flags; line store contents are not cleared. An m_axis stall freezes
// the back end; the front keeps taking items until the queue is committed.
`default_nettype none
module separable_box_blur_3x3 import sbb_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [LEN_W-1:0]    cfg_wdata,       // row_length
	input  wire logic                s_axis_tvalid,
	output logic                     s_axis_tready,
	input  wire logic [SAMPLE_W-1:0] s_axis_tdata,    // [31:0] sample
	input  wire logic                s_axis_tuser,    // [0] frame_start
	output logic                     m_axis_tvalid,
	input  wire logic                m_axis_tready,
	output logic [SAMPLE_W-1:0]      m_axis_tdata,    // [31:0] blurred
	output logic                     m_axis_tlast     // row_end
);

	logic               push_valid;
	sbb_item_t          push_item;
	logic               head_valid;
	sbb_item_t          head_item;
	logic               pop;
	logic [Q_CNT_W-1:0] q_count;

	sbb_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.sample      (s_axis_tdata),
		.frame_start (s_axis_tuser),
		.q_count     (q_count),
		.push_valid  (push_valid),
		.push_item   (push_item)
	);

	sbb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_item  (push_item),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item),
		.count      (q_count)
	);

	sbb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.blurred    (m_axis_tdata),
		.row_end    (m_axis_tlast)
	);

endmodule
`default_nettype wire

/* hw/rtl/sbb_checker.sv */
// Port-level checks for the separable 3x3 box blur, bound to the top level.
// Uses sbb_pkg.
`default_nettype none
module sbb_checker import sbb_pkg::*; (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                s_axis_tvalid,
	input wire logic                s_axis_tready,
	input wire logic                m_axis_tvalid,
	input wire logic                m_axis_tready,
	input wire logic [SAMPLE_W-1:0] m_axis_tdata,
	input wire logic                m_axis_tlast
);

	logic [15:0] pend_q;
	logic        sat_q;
	logic        seen_q;
	logic        in_acc;
	logic        out_acc;

	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign out_acc = m_axis_tvalid && m_axis_tready;

	// items taken minus results given, floored at zero; a sticky flag marks saturation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			sat_q  <= 1'b0;
			seen_q <= 1'b0;
		end else begin
			if (in_acc)
				seen_q <= 1'b1;
			if (in_acc && !out_acc) begin
				if (pend_q == '1)
					sat_q <= 1'b1;
				else
					pend_q <= pend_q + 16'd1;
			end else if (!in_acc && out_acc && pend_q != '0) begin
				pend_q <= pend_q - 16'd1;
			end
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("result changed while stalled");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> (sat_q || pend_q != '0 || in_acc))
		else $error("result without a preceding item");

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> seen_q)
		else $error("input stalled with nothing taken");

	a_first_late: assert property (@(posedge clk) disable iff (!arst_n)
		!seen_q |-> !m_axis_tvalid)
		else $error("result before any item");

endmodule

bind separable_box_blur_3x3 sbb_checker u_sbb_checker (.*);
`default_nettype wire

/* bench/separable_box_blur_3x3_tb.sv */
// Self-checking bench for separable_box_blur_3x3: a queue-fed stream driver, a
// monitor with a bit-true predictor of the two rounded divide-by-three stages.
// Depends on sbb_pkg and the separable_box_blur_3x3 RTL.
`default_nettype none
module separable_box_blur_3x3_tb;
	import sbb_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 24;
	localparam int ITEM_TARGET    = 1800;
	localparam int ROW_COUNT_MAX  = 16'hFFFF;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 32'h7FFF_FFFF;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 32'h8000_0000;

	typedef enum {FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY} flow_mode_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                frame_start;
	} blur_in_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] blurred;
		logic                row_end;
	} blur_out_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [LEN_W-1:0]    cfg_wdata = '0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [SAMPLE_W-1:0] s_axis_tdata = '0;     // [31:0] sample
	logic                s_axis_tuser = 1'b0;   // [0] frame_start
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [SAMPLE_W-1:0] m_axis_tdata;          // [31:0] blurred
	logic                m_axis_tlast;          // row_end

	separable_box_blur_3x3 dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial forever #1 clk = ~clk;

	blur_in_t  pending_items[$];
	blur_out_t expected_results[$];
	blur_out_t oldest_result;
	int        fail_count = 0;
	int        items_pushed = 0;
	int        stall_cycles = 0;
	int        gap_left = 0;
	int        burst_left = 0;
	int        ready_step = 0;
	logic [15:0] ready_pattern = 16'hFFFF;
	flow_mode_t sender_mode = FLOW_LIGHT;
	flow_mode_t receiver_mode = FLOW_LIGHT;

	// predictor state
	logic signed [SAMPLE_W-1:0] older_line [MAX_COLUMNS];
	logic signed [SAMPLE_W-1:0] upper_line [MAX_COLUMNS];
	logic signed [SAMPLE_W-1:0] col_avg_win [2];
	int unsigned                col_pos = 0;
	int unsigned                row_pos = 0;
	logic [LEN_W-1:0]           row_len_reg = ROW_LEN_RESET;

	function automatic int unsigned clamp_row_length(input logic [LEN_W-1:0] v);
		if (v < ROW_LEN_MIN)
			return 32'(ROW_LEN_MIN);
		if (v > ROW_LEN_MAX)
			return 32'(ROW_LEN_MAX);
		return 32'(v);
	endfunction

	// round to nearest; no tie is possible for a divide by three
	function automatic logic signed [SAMPLE_W-1:0] div3_round(input longint s);
		if (s >= 0)
			return SAMPLE_W'((s + 1) / 3);
		return SAMPLE_W'(-((-s + 1) / 3));
	endfunction

	task automatic predict_blur(input blur_in_t item);
		int unsigned len;
		int unsigned col;
		logic signed [SAMPLE_W-1:0] vert;
		blur_out_t res;
		len = clamp_row_length(row_len_reg);
		if (item.frame_start) begin
			col_pos = 0;
			row_pos = 0;
		end
		col = (col_pos >= MAX_COLUMNS) ? MAX_COLUMNS - 1 : col_pos;
		vert = '0;
		if (row_pos >= 2) begin
			vert = div3_round(longint'(older_line[col]) + longint'(upper_line[col]) +
				longint'($signed(item.sample)));
			if (col >= 2) begin
				res.blurred = div3_round(longint'(col_avg_win[0]) +
					longint'(col_avg_win[1]) + longint'(vert));
				res.row_end = (col + 1 >= len);
				expected_results.push_back(res);
			end
		end
		col_avg_win[0] = col_avg_win[1];
		col_avg_win[1] = vert;
		older_line[col] = upper_line[col];
		upper_line[col] = item.sample;
		if (col + 1 >= len) begin
			col_pos = 0;
			if (row_pos < ROW_COUNT_MAX)
				row_pos++;
		end else begin
			col_pos = col + 1;
		end
	endtask

	task automatic report_mismatch(input string what, input logic [SAMPLE_W-1:0] want,
		input logic [SAMPLE_W-1:0] got);
		fail_count++;
		if (fail_count <= 10)
			$display("mismatch on %s: expected %h, got %h", what, want, got);
	endtask

	// driver: bursts with random gaps, valid held until taken
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				predict_blur(pending_items.pop_front());
			if (s_axis_tvalid && !s_axis_tready) begin
				// hold the item on offer
			end else if (gap_left > 0) begin
				gap_left--;
				s_axis_tvalid <= 1'b0;
			end else if (pending_items.size() != 0) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= pending_items[0].sample;
				s_axis_tuser  <= pending_items[0].frame_start;
				if (burst_left > 0) begin
					burst_left--;
				end else if (sender_mode != FLOW_FREE) begin
					burst_left = $urandom_range(0, (sender_mode == FLOW_HEAVY) ? 4 : 16);
					gap_left   = $urandom_range(0, (sender_mode == FLOW_HEAVY) ? 12 : 3);
				end
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// monitor and receiver stall pattern
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result", '0, m_axis_tdata);
				end else begin
					oldest_result = expected_results.pop_front();
					if (m_axis_tdata !== oldest_result.blurred)
						report_mismatch("blurred", oldest_result.blurred, m_axis_tdata);
					if (m_axis_tlast !== oldest_result.row_end)
						report_mismatch("row_end", SAMPLE_W'(oldest_result.row_end),
							SAMPLE_W'(m_axis_tlast));
				end
			end
			ready_step = (ready_step + 1) % 16;
			if (ready_step == 0 && $urandom_range(0, 3) == 0) begin
				if (receiver_mode == FLOW_HEAVY)
					ready_pattern = 16'($urandom() & $urandom());
				else
					ready_pattern = 16'($urandom() | $urandom());
				ready_pattern[0] = 1'b1;
			end
			m_axis_tready <= (receiver_mode == FLOW_FREE) ? 1'b1 : ready_pattern[ready_step];
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			stall_cycles = 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("separable_box_blur_3x3_tb failed");
			$finish;
		end else begin
			stall_cycles++;
		end
	end

	function automatic logic [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			2: return SAMPLE_W'($urandom_range(0, 8)) - SAMPLE_W'(4);
			3: return SAMPLE_MAX - SAMPLE_W'($urandom_range(0, 255));
			4: return SAMPLE_MIN + SAMPLE_W'($urandom_range(0, 255));
			default: return SAMPLE_W'($urandom());
		endcase
	endfunction

	task automatic push_item(input logic [SAMPLE_W-1:0] sample, input logic frame_start);
		blur_in_t item;
		item.sample      = sample;
		item.frame_start = frame_start;
		pending_items.push_back(item);
		items_pushed++;
	endtask

	task automatic wait_for_drain();
		@(negedge clk);
		while (pending_items.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
			@(negedge clk);
	endtask

	// only while idle; the block may still be busy on items with no result
	task automatic write_row_length(input logic [LEN_W-1:0] value);
		wait_for_drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
		@(posedge clk);
		cfg_we      <= 1'b1;
		cfg_wdata   <= value;
		row_len_reg = value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// full rows plus a partial one; noisy frames carry stray frame starts
	task automatic push_frame(input int len, input int rows, input int extra,
		input logic start, input logic noisy, input int pause_row);
		int n;
		for (int r = 0; r <= rows; r++) begin
			n = (r == rows) ? extra : len;
			if (r == pause_row)
				wait_for_drain();
			for (int c = 0; c < n; c++) begin
				if (r == 0 && c == 0)
					push_item(pick_sample(), start);
				else
					push_item(pick_sample(), noisy && $urandom_range(0, 63) == 0);
			end
		end
	endtask

	initial begin
		int stage_no;
		int len;
		int rows;
		logic [LEN_W-1:0] cfg_value;
		stage_no = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset row length of four: saturating extremes, then a restart at a row start
		for (int c = 0; c < 4; c++)
			push_item(SAMPLE_MAX, 1'b0);
		for (int c = 0; c < 4; c++)
			push_item(SAMPLE_MIN, 1'b0);
		push_item(SAMPLE_MAX, 1'b0);
		push_item(SAMPLE_MIN, 1'b0);
		push_item(32'h0000_0001, 1'b0);
		push_item(32'hFFFF_FFFF, 1'b0);
		push_item(32'hFFFF_8000, 1'b1);
		// zero acts as the shortest row
		write_row_length('0);
		for (int c = 0; c < 9; c++)
			push_item(SAMPLE_MIN, c == 0);
		for (int c = 0; c < 3; c++)
			push_item(SAMPLE_MAX, 1'b0);

		while (items_pushed < ITEM_TARGET) begin
			stage_no++;
			sender_mode   = flow_mode_t'($urandom_range(0, 2));
			receiver_mode = flow_mode_t'($urandom_range(0, 2));
			if (stage_no == 2) begin
				// largest register value acts as the longest row: no early wrap
				write_row_length(11'h7FF);
				push_frame(clamp_row_length(row_len_reg), 1, 3, 1'b1, 1'b0, -1);
			end else if (stage_no == 3) begin
				// shrink mid-frame, no new frame start
				cfg_value = LEN_W'($urandom_range(8, 12));
				write_row_length(cfg_value);
				push_frame(int'(cfg_value), 2, $urandom_range(0, int'(cfg_value) - 1),
					1'b1, 1'b0, -1);
				write_row_length(LEN_W'($urandom_range(3, int'(cfg_value) - 1)));
				push_frame(clamp_row_length(row_len_reg), 3, 0, 1'b0, 1'b0, -1);
			end else begin
				case ($urandom_range(0, 7))
					0: cfg_value = LEN_W'($urandom_range(0, 2));
					1: cfg_value = ROW_LEN_MIN;
					2: cfg_value = LEN_W'($urandom_range(13, 48));
					default: cfg_value = LEN_W'($urandom_range(3, 12));
				endcase
				write_row_length(cfg_value);
				len = clamp_row_length(row_len_reg);
				for (int f = (len > 12) ? 1 : int'($urandom_range(1, 4)); f > 0; f--) begin
					if (len > 12)
						rows = 3;
					else if ($urandom_range(0, 4) == 0)
						rows = $urandom_range(0, 2);
					else
						rows = $urandom_range(3, 8);
					push_frame(len, rows, $urandom_range(0, len - 1), 1'b1,
						$urandom_range(0, 3) == 0,
						($urandom_range(0, 3) == 0) ? int'($urandom_range(1, rows)) : -1);
				end
			end
		end

		wait_for_drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (fail_count == 0) begin
			$display("separable_box_blur_3x3_tb passed");
		end else begin
			$display("separable_box_blur_3x3_tb failed");
		end
		$finish;
	end

endmodule
`default_nettype wire

/* filelist.f */
hw/rtl/sbb_pkg.sv
hw/rtl/sbb_ram.sv
hw/rtl/sbb_front.sv
hw/rtl/sbb_queue.sv
hw/rtl/sbb_back.sv
hw/rtl/separable_box_blur_3x3.sv
hw/rtl/sbb_checker.sv
bench/separable_box_blur_3x3_tb.sv
